@@ design/fcgi_pkg.sv @@
// Shared types and constants for the record deframer.
// Holds the result-kind, error and phase codes and the result struct.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package fcgi_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_VERSION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TYPE    = 1'd1;

   localparam logic [7:0] EXP_VERSION_RESET = 8'd1;
   localparam logic [7:0] MAX_TYPE_RESET    = 8'd11;

   // Result kinds.
   localparam logic [3:0] KIND_HEADER     = 4'd0;
   localparam logic [3:0] KIND_SCAN       = 4'd1;
   localparam logic [3:0] KIND_CLIENT     = 4'd2;
   localparam logic [3:0] KIND_DROPPED    = 4'd3;
   localparam logic [3:0] KIND_STDERR     = 4'd4;
   localparam logic [3:0] KIND_DISCARD    = 4'd5;
   localparam logic [3:0] KIND_END_BODY   = 4'd6;
   localparam logic [3:0] KIND_END_DONE   = 4'd7;
   localparam logic [3:0] KIND_ERROR      = 4'd8;

   // Error codes.
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_VERSION     = 3'd1;
   localparam logic [2:0] ERR_TYPE        = 3'd2;
   localparam logic [2:0] ERR_END_LENGTH  = 3'd3;
   localparam logic [2:0] ERR_END_STATUS  = 3'd4;

   // Stream phases.
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_CONTENT = 2'd1;
   localparam logic [1:0] PH_PADDING = 2'd2;

   // Record types with special handling.
   localparam logic [7:0] T_END    = 8'd3;
   localparam logic [7:0] T_STDOUT = 8'd6;
   localparam logic [7:0] T_STDERR = 8'd7;

   // Scan modes.
   localparam logic [1:0] MODE_SCAN   = 2'd0;
   localparam logic [1:0] MODE_CLIENT = 2'd1;

   // Header byte positions.
   localparam logic [2:0] HB_VERSION  = 3'd0;
   localparam logic [2:0] HB_TYPE     = 3'd1;
   localparam logic [2:0] HB_LEN_HIGH = 3'd4;
   localparam logic [2:0] HB_LEN_LOW  = 3'd5;
   localparam logic [2:0] HB_PADDING  = 3'd6;
   localparam logic [2:0] HB_LAST     = 3'd7;

   localparam logic [15:0] END_BODY_LEN = 16'd8;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  record_kind;
      logic [31:0] exit_status;
      logic [2:0]  error_code;
   } result_type;

endpackage

`default_nettype wire

@@ design/fcgi_core.sv @@
// Deframer state and the single-pass routing logic for one byte.
// Also holds the two configuration registers.
// Depends on fcgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcgi_core import fcgi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata,
   input  wire logic [7:0]           in_byte,
   input  wire logic [1:0]           in_mode,
   input  wire logic                 step,
   output result_type                result
);

   logic [7:0]  exp_ver_ff, max_type_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [39:0] hstore_ff, hstore_in;
   logic [15:0] content_ff, content_in;
   logic [7:0]  pad_ff, pad_in;
   logic [7:0]  ctype_ff, ctype_in;
   logic [55:0] ebody_ff, ebody_in;
   logic [2:0]  err_ff, err_in;

   logic [7:0]  hdr_ver, hdr_type, hdr_pad;
   logic [15:0] hdr_len;
   logic [15:0] content_dec;
   logic [7:0]  pad_dec;
   logic        status_bad;

   assign hdr_ver  = hstore_in[39:32];
   assign hdr_type = hstore_in[31:24];
   assign hdr_len  = hstore_in[23:8];
   assign hdr_pad  = hstore_in[7:0];
   assign content_dec = content_ff - 16'd1;
   assign pad_dec     = (pad_ff != 8'd0) ? pad_ff - 8'd1 : 8'd0;

   always_comb begin
      phase_in   = phase_ff;
      hcount_in  = hcount_ff;
      hstore_in  = hstore_ff;
      content_in = content_ff;
      pad_in     = pad_ff;
      ctype_in   = ctype_ff;
      ebody_in   = ebody_ff;
      err_in     = err_ff;
      status_bad = 1'b0;

      result.kind        = KIND_HEADER;
      result.data_byte   = in_byte;
      result.record_kind = ctype_ff;
      result.exit_status = 32'd0;

      if (err_ff != ERR_NONE) begin
         result.kind = KIND_ERROR;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               unique case (hcount_ff)
                  HB_VERSION:  hstore_in[39:32] = in_byte;
                  HB_TYPE:     hstore_in[31:24] = in_byte;
                  HB_LEN_HIGH: hstore_in[23:16] = in_byte;
                  HB_LEN_LOW:  hstore_in[15:8]  = in_byte;
                  HB_PADDING:  hstore_in[7:0]   = in_byte;
                  default:     hstore_in        = hstore_ff;
               endcase
               if (hcount_ff != HB_LAST) begin
                  hcount_in          = hcount_ff + 3'd1;
                  result.record_kind = 8'd0;
               end else begin
                  // Last header byte: check the header and enter the record.
                  hcount_in          = 3'd0;
                  ctype_in           = hdr_type;
                  result.record_kind = hdr_type;
                  priority if (hdr_ver != exp_ver_ff) begin
                     err_in = ERR_VERSION;
                  end else if (hdr_type > max_type_ff) begin
                     err_in = ERR_TYPE;
                  end else if (hdr_type == T_END && hdr_len != END_BODY_LEN) begin
                     err_in = ERR_END_LENGTH;
                  end else begin
                     err_in = ERR_NONE;
                  end
                  if (err_in != ERR_NONE) begin
                     result.kind = KIND_ERROR;
                  end else begin
                     content_in = hdr_len;
                     pad_in     = hdr_pad;
                     if (hdr_len != 16'd0) begin
                        phase_in = PH_CONTENT;
                     end else if (hdr_pad != 8'd0) begin
                        phase_in = PH_PADDING;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
            end
            PH_CONTENT: begin
               content_in = content_dec;
               priority if (ctype_ff == T_STDOUT) begin
                  unique case (in_mode)
                     MODE_SCAN:   result.kind = KIND_SCAN;
                     MODE_CLIENT: result.kind = KIND_CLIENT;
                     default:     result.kind = KIND_DROPPED;
                  endcase
               end else if (ctype_ff == T_STDERR) begin
                  result.kind = KIND_STDERR;
               end else if (ctype_ff == T_END) begin
                  ebody_in    = {ebody_ff[47:0], in_byte};
                  result.kind = KIND_END_BODY;
                  if (content_dec == 16'd0) begin
                     // Protocol status is body byte four; application status
                     // is body bytes zero to three, big-endian.
                     if (ebody_ff[23:16] != 8'd0) begin
                        status_bad  = 1'b1;
                        err_in      = ERR_END_STATUS;
                        result.kind = KIND_ERROR;
                     end else begin
                        result.kind        = KIND_END_DONE;
                        result.exit_status = ebody_ff[55:24];
                     end
                  end
               end else begin
                  result.kind = KIND_DISCARD;
               end
               if (content_dec == 16'd0 && !status_bad) begin
                  phase_in = (pad_ff != 8'd0) ? PH_PADDING : PH_HEADER;
               end
            end
            default: begin
               pad_in = pad_dec;
               if (pad_dec == 8'd0) begin
                  phase_in = PH_HEADER;
               end
            end
         endcase
      end

      result.error_code = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ver_ff  <= EXP_VERSION_RESET;
         max_type_ff <= MAX_TYPE_RESET;
         phase_ff    <= PH_HEADER;
         hcount_ff   <= 3'd0;
         content_ff  <= 16'd0;
         pad_ff      <= 8'd0;
         ctype_ff    <= 8'd0;
         err_ff      <= ERR_NONE;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_EXP_VERSION: exp_ver_ff  <= csr_wdata;
               CSR_MAX_TYPE:    max_type_ff <= csr_wdata;
            endcase
         end
         if (step) begin
            phase_ff   <= phase_in;
            hcount_ff  <= hcount_in;
            content_ff <= content_in;
            pad_ff     <= pad_in;
            ctype_ff   <= ctype_in;
            err_ff     <= err_in;
         end
      end
   end

   // Header and end-body bytes are always written before they are read.
   always_ff @(posedge clock) begin
      if (step) begin
         hstore_ff <= hstore_in;
         ebody_ff  <= ebody_in;
      end
   end

endmodule

`default_nettype wire

@@ design/fcgi_out_stage.sv @@
// Result register of the deframer with its valid flag.
// Holds a finished beat until the consumer takes it.
// Depends on fcgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcgi_out_stage import fcgi_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire result_type  in_result,
   output logic             in_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_record_kind,
   output logic [31:0]      rsp_exit_status,
   output logic [2:0]       rsp_error_code
);

   logic       vld_ff, vld_in;
   result_type res_ff;

   assign in_ready = !vld_ff || rsp_ready;
   assign vld_in   = in_ready ? in_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ff <= in_result;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_kind        = res_ff.kind;
   assign rsp_data_byte   = res_ff.data_byte;
   assign rsp_record_kind = res_ff.record_kind;
   assign rsp_exit_status = res_ff.exit_status;
   assign rsp_error_code  = res_ff.error_code;

endmodule

`default_nettype wire

@@ design/fastcgi_record_deframer_unit.sv @@
// Record deframer top level: input register, routing core, result register.
// A beat moves from the input register through fcgi_core into the result register.
// Throughput: one byte per cycle unless rsp_ready stalls; fcgi_core is single-pass.
// Synchronous active-high reset empties both registers, restores the
// configuration defaults and returns the parser to the header phase with no error.
// Depends on fcgi_pkg, fcgi_core and fcgi_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module fastcgi_record_deframer_unit import fcgi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_rx_byte,
   input  wire logic [1:0]           req_stdout_mode,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [3:0]                rsp_kind,
   output logic [7:0]                rsp_data_byte,
   output logic [7:0]                rsp_record_kind,
   output logic [31:0]               rsp_exit_status,
   output logic [2:0]                rsp_error_code,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata
);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic [1:0] in_mode_ff;
   logic       out_ready;
   logic       step;
   result_type core_result;

   // The input register moves on whenever the result register can take a beat.
   assign req_ready = !in_vld_ff || out_ready;
   assign in_vld_in = req_ready ? req_valid : in_vld_ff;
   assign step      = in_vld_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
         in_mode_ff <= req_stdout_mode;
      end
   end

   fcgi_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_byte   (in_byte_ff),
      .in_mode   (in_mode_ff),
      .step      (step),
      .result    (core_result)
   );

   fcgi_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (in_vld_ff),
      .in_result       (core_result),
      .in_ready        (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_record_kind (rsp_record_kind),
      .rsp_exit_status (rsp_exit_status),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

`default_nettype wire

@@ design/fcgi_checker.sv @@
// Port-level checks for the record deframer, bound to the top level.
// Depends on fcgi_pkg and fastcgi_record_deframer_unit.
`timescale 1ns / 1ps
`default_nettype none

module fcgi_checker import fcgi_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [3:0]           rsp_kind,
   input wire logic [7:0]           rsp_data_byte,
   input wire logic [7:0]           rsp_record_kind,
   input wire logic [31:0]          rsp_exit_status,
   input wire logic [2:0]           rsp_error_code
);

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_data_byte) && $stable(rsp_record_kind) && $stable(rsp_exit_status) &&
      $stable(rsp_error_code))
      else $error("result beat changed while stalled");

   // Error beats carry an error code, and every other beat carries none.
   a_err_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // Exit status is only nonzero on a completed end record.
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_END_DONE |-> rsp_exit_status == 32'd0)
      else $error("exit status set outside end completion");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind fastcgi_record_deframer_unit fcgi_checker u_fcgi_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for fastcgi_record_deframer_unit: drives well-formed records and a
// closing bad one under several register settings, predicts and checks every beat.
// Depends on fcgi_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module testbench;
   import fcgi_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [7:0] rx;
      logic [1:0] mode;
   } stream_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_rx_byte = 8'd0;
   logic [1:0]           req_stdout_mode = 2'd0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [3:0]           rsp_kind;
   logic [7:0]           rsp_data_byte;
   logic [7:0]           rsp_record_kind;
   logic [31:0]          rsp_exit_status;
   logic [2:0]           rsp_error_code;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_EXP_VERSION;
   logic [7:0]           csr_wdata = 8'd0;

   // Stimulus and expectation stores.
   stream_beat_type stream_beats[$];
   result_type      pending_routes[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned beats_queued = 0;
   int unsigned records_queued = 0;
   int unsigned routes_checked = 0;
   int unsigned mismatch_count = 0;
   logic [2:0]  last_error_seen = ERR_NONE;

   // Deframer state as seen by the predictor.
   logic [7:0]  cfg_version = EXP_VERSION_RESET;
   logic [7:0]  cfg_max_type = MAX_TYPE_RESET;
   logic [1:0]  parse_phase = PH_HEADER;
   logic [2:0]  hdr_count = 3'd0;
   logic [39:0] hdr_fields = 40'd0;
   logic [15:0] content_left = 16'd0;
   logic [7:0]  padding_left = 8'd0;
   logic [7:0]  rec_type = 8'd0;
   logic [63:0] end_body = 64'd0;
   logic [2:0]  held_error = ERR_NONE;

   fastcgi_record_deframer_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_stdout_mode (req_stdout_mode),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_record_kind (rsp_record_kind),
      .rsp_exit_status (rsp_exit_status),
      .rsp_error_code  (rsp_error_code),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // Advances the parser state by one stream byte and returns its routing.
   function automatic result_type route_byte(input logic [7:0] b, input logic [1:0] mode);
      result_type r;
      r.kind        = KIND_HEADER;
      r.data_byte   = b;
      r.record_kind = 8'd0;
      r.exit_status = 32'd0;
      if (held_error != ERR_NONE) begin
         r.kind        = KIND_ERROR;
         r.record_kind = rec_type;
      end else if (parse_phase == PH_HEADER) begin
         case (hdr_count)
            HB_VERSION:  hdr_fields[39:32] = b;
            HB_TYPE:     hdr_fields[31:24] = b;
            HB_LEN_HIGH: hdr_fields[23:16] = b;
            HB_LEN_LOW:  hdr_fields[15:8]  = b;
            HB_PADDING:  hdr_fields[7:0]   = b;
            default: ;
         endcase
         if (hdr_count != HB_LAST) begin
            hdr_count = hdr_count + 3'd1;
         end else begin
            hdr_count     = 3'd0;
            rec_type      = hdr_fields[31:24];
            r.record_kind = rec_type;
            // Version is checked before the type limit, which comes before the length.
            if (hdr_fields[39:32] != cfg_version)
               held_error = ERR_VERSION;
            else if (rec_type > cfg_max_type)
               held_error = ERR_TYPE;
            else if (rec_type == T_END && hdr_fields[23:8] != END_BODY_LEN)
               held_error = ERR_END_LENGTH;
            if (held_error != ERR_NONE) begin
               r.kind = KIND_ERROR;
            end else begin
               content_left = hdr_fields[23:8];
               padding_left = hdr_fields[7:0];
               if (content_left != 16'd0)
                  parse_phase = PH_CONTENT;
               else
                  parse_phase = (padding_left != 8'd0) ? PH_PADDING : PH_HEADER;
            end
         end
      end else if (parse_phase == PH_CONTENT) begin
         content_left  = content_left - 16'd1;
         r.record_kind = rec_type;
         if (rec_type == T_STDOUT) begin
            r.kind = (mode == MODE_SCAN) ? KIND_SCAN :
                     (mode == MODE_CLIENT) ? KIND_CLIENT : KIND_DROPPED;
         end else if (rec_type == T_STDERR) begin
            r.kind = KIND_STDERR;
         end else if (rec_type == T_END) begin
            end_body = {end_body[55:0], b};
            r.kind   = KIND_END_BODY;
            if (content_left == 16'd0) begin
               // Body byte 4 is the protocol status; bytes 0..3 the exit status.
               if (end_body[31:24] != 8'd0) begin
                  held_error = ERR_END_STATUS;
                  r.kind     = KIND_ERROR;
               end else begin
                  r.kind        = KIND_END_DONE;
                  r.exit_status = end_body[63:32];
               end
            end
         end else begin
            r.kind = KIND_DISCARD;
         end
         if (r.kind != KIND_ERROR && content_left == 16'd0)
            parse_phase = (padding_left != 8'd0) ? PH_PADDING : PH_HEADER;
      end else begin
         r.record_kind = rec_type;
         if (padding_left != 8'd0)
            padding_left = padding_left - 8'd1;
         if (padding_left == 8'd0)
            parse_phase = PH_HEADER;
      end
      r.error_code = held_error;
      return r;
   endfunction

   function automatic void put_beat(input logic [7:0] b, input logic [1:0] mode);
      stream_beat_type s;
      s.rx   = b;
      s.mode = mode;
      stream_beats.push_back(s);
      beats_queued++;
   endfunction

   // Queues one record: header, content and padding. Directed records use fixed
   // content patterns and step through every scan mode.
   task automatic push_record(input logic [7:0] ver, input logic [7:0] typ,
                              input logic [15:0] len, input logic [7:0] pad,
                              input logic [7:0] end_status, input bit directed);
      logic [7:0] hdr [8];
      logic [7:0] b;
      hdr = '{ver, typ, 8'($urandom), 8'($urandom), len[15:8], len[7:0], pad,
              8'($urandom)};
      for (int i = 0; i < 8; i++)
         put_beat(hdr[i], 2'($urandom_range(3)));
      for (int i = 0; i < int'(len); i++) begin
         if (typ == T_END && i == 4)
            b = end_status;
         else if (directed && typ == T_END)
            b = (i < 4) ? 8'hFF : 8'h00;
         else if (directed)
            b = (i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'hFF : (i % 4 == 2) ? 8'h55 : 8'hAA;
         else
            b = 8'($urandom);
         put_beat(b, directed ? 2'(i) : 2'($urandom_range(3)));
      end
      for (int i = 0; i < int'(pad); i++)
         put_beat(8'($urandom), 2'($urandom_range(3)));
      records_queued++;
   endtask

   // A well-formed record under the current settings, biased toward routed types.
   task automatic random_record();
      logic [7:0]  typ;
      logic [7:0]  pad;
      logic [15:0] len;
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick <= 2)
         typ = T_STDOUT;
      else if (pick <= 4)
         typ = T_STDERR;
      else if (pick == 5)
         typ = T_END;
      else
         typ = 8'($urandom_range(cfg_max_type));
      if (typ > cfg_max_type)
         typ = 8'($urandom_range(cfg_max_type));
      pick = $urandom_range(99);
      if (typ == T_END)
         len = END_BODY_LEN;
      else if (pick < 80)
         len = 16'($urandom_range(16));
      else if (pick < 97)
         len = 16'($urandom_range(64, 17));
      else
         len = 16'($urandom_range(520, 256));
      pad = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
      push_record(cfg_version, typ, len, pad, 8'd0, 1'b0);
   endtask

   task automatic fill_records(input int unsigned budget);
      int unsigned start;
      start = beats_queued;
      while (beats_queued - start < budget)
         random_record();
   endtask

   // Checked on the falling edge so that every update of the rising edge has landed.
   task automatic wait_drained();
      while (stream_beats.size() != 0 || req_valid || pending_routes.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_EXP_VERSION)
         cfg_version = val;
      else
         cfg_max_type = val;
   endtask

   task automatic run_phase(input logic [7:0] ver, input logic [7:0] max_type,
                            input int unsigned send_pct, input int unsigned recv_pct,
                            input int unsigned budget);
      wait_drained();
      write_csr(CSR_EXP_VERSION, ver);
      write_csr(CSR_MAX_TYPE, max_type);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      fill_records(budget);
   endtask

   // Ends the run with one protocol error; it stays held, so it can only come last.
   task automatic inject_error();
      logic [2:0] err_pick;
      err_pick = 3'($urandom_range(4, 1));
      wait_drained();
      write_csr(CSR_EXP_VERSION, 8'($urandom));
      // A limit below END lets a bad END length show that the type check wins.
      write_csr(CSR_MAX_TYPE, (err_pick == ERR_TYPE) ? 8'd2 : 8'd200);
      random_record();
      case (err_pick)
         ERR_VERSION:    push_record(~cfg_version, 8'hFF, 16'd3, 8'd0, 8'd0, 1'b0);
         ERR_TYPE:       push_record(cfg_version, T_END, 16'd5, 8'd0, 8'd0, 1'b0);
         ERR_END_LENGTH: push_record(cfg_version, T_END, 16'($urandom_range(7)), 8'd2,
                                     8'd0, 1'b0);
         default:        push_record(cfg_version, T_END, END_BODY_LEN, 8'd1,
                                     8'($urandom_range(255, 1)), 1'b0);
      endcase
      repeat (24)
         put_beat(8'($urandom), 2'($urandom_range(3)));
   endtask

   // Sender: predicts each accepted beat, then offers the next one or idles.
   always @(posedge clock) begin : drive_stream
      stream_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            pending_routes.push_back(route_byte(req_rx_byte, req_stdout_mode));
         if (!req_valid || req_ready) begin
            if (stream_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = stream_beats.pop_front();
               req_valid       <= 1'b1;
               req_rx_byte     <= nxt.rx;
               req_stdout_mode <= nxt.mode;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: random backpressure and comparison against the oldest prediction.
   always @(posedge clock) begin : watch_routes
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_routes.size() == 0) begin
               $display("%t: unexpected result beat, expected none, actual kind %0d data %h",
                        $time, rsp_kind, rsp_data_byte);
               mismatch_count++;
            end else begin
               want = pending_routes.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
               check_field("record_kind", 32'(want.record_kind), 32'(rsp_record_kind));
               check_field("exit_status", want.exit_status, rsp_exit_status);
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
               routes_checked++;
               last_error_seen = rsp_error_code;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at the reset settings: every scan mode, extreme bytes,
      // padding after content and an END body with an all-ones exit status.
      send_idle_pct = 28;
      recv_idle_pct = 86;
      push_record(EXP_VERSION_RESET, T_STDOUT, 16'd4, 8'd1, 8'd0, 1'b1);
      push_record(EXP_VERSION_RESET, T_END, END_BODY_LEN, 8'd0, 8'd0, 1'b1);
      fill_records(220);

      run_phase(8'h00, 8'hFF, 28, 86, 250);
      run_phase(8'hFF, 8'h00, 86, 28, 150);
      run_phase(8'h5A, 8'h07, 86, 28, 250);
      run_phase(8'hA5, T_END, 0, 0, 250);
      run_phase(8'($urandom), 8'($urandom_range(255, 7)), 0, 0, 300);
      inject_error();

      wait_drained();
      repeat (6) @(posedge clock);
      $display("Streamed %0d bytes in %0d records over seven register settings.",
               beats_queued, records_queued);
      $display("Checked %0d result beats, %0d mismatches, ending on held error %0d.",
               routes_checked, mismatch_count, last_error_seen);
      if (mismatch_count == 0 && pending_routes.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
